[sv/bsed_pkg.sv]
// Shared types, character codes and limits for the backslash escape decoder.
`timescale 1ns / 1ps

package bsed_pkg;

    localparam int MAX_RESULTS         = 4;
    localparam int RES_IDX_W           = $clog2(MAX_RESULTS);
    localparam int RES_CNT_W           = $clog2(MAX_RESULTS + 1);
    localparam int QUEUE_DEPTH_DEFAULT = 2;

    localparam logic [7:0] CH_BACKSLASH = 8'h5C;
    localparam logic [7:0] CH_ZERO      = 8'h30;
    localparam logic [7:0] CH_SEVEN     = 8'h37;
    localparam logic [7:0] CH_NINE      = 8'h39;
    localparam logic [7:0] CH_LC_A      = 8'h61;
    localparam logic [7:0] CH_LC_B      = 8'h62;
    localparam logic [7:0] CH_LC_C      = 8'h63;
    localparam logic [7:0] CH_LC_E      = 8'h65;
    localparam logic [7:0] CH_LC_F      = 8'h66;
    localparam logic [7:0] CH_LC_N      = 8'h6E;
    localparam logic [7:0] CH_LC_R      = 8'h72;
    localparam logic [7:0] CH_LC_T      = 8'h74;
    localparam logic [7:0] CH_LC_U      = 8'h75;
    localparam logic [7:0] CH_LC_V      = 8'h76;
    localparam logic [7:0] CH_LC_X      = 8'h78;
    localparam logic [7:0] CH_UC_A      = 8'h41;
    localparam logic [7:0] CH_UC_E      = 8'h45;
    localparam logic [7:0] CH_UC_F      = 8'h46;
    localparam logic [7:0] CH_UC_U      = 8'h55;

    localparam logic [7:0] CODE_BEL = 8'h07;
    localparam logic [7:0] CODE_BS  = 8'h08;
    localparam logic [7:0] CODE_TAB = 8'h09;
    localparam logic [7:0] CODE_LF  = 8'h0A;
    localparam logic [7:0] CODE_VT  = 8'h0B;
    localparam logic [7:0] CODE_FF  = 8'h0C;
    localparam logic [7:0] CODE_CR  = 8'h0D;
    localparam logic [7:0] CODE_ESC = 8'h1B;

    localparam logic [31:0] CP_MAX_1BYTE   = 32'h0000_007F;
    localparam logic [31:0] CP_MAX_2BYTE   = 32'h0000_07FF;
    localparam logic [31:0] CP_MAX_3BYTE   = 32'h0000_FFFF;
    localparam logic [31:0] CP_MAX_4BYTE   = 32'h0010_FFFF;
    localparam logic [31:0] CP_SURR_FIRST  = 32'h0000_D800;
    localparam logic [31:0] CP_SURR_LAST   = 32'h0000_DFFF;

    localparam logic [7:0] UTF8_LEAD2 = 8'hC0;
    localparam logic [7:0] UTF8_LEAD3 = 8'hE0;
    localparam logic [7:0] UTF8_LEAD4 = 8'hF0;
    localparam logic [7:0] UTF8_CONT  = 8'h80;

    typedef enum logic [6:0] {
        PH_PLAIN = 7'b000_0001,
        PH_ESC   = 7'b000_0010,
        PH_HEX   = 7'b000_0100,
        PH_UNI4  = 7'b000_1000,
        PH_UNI8  = 7'b001_0000,
        PH_OCT   = 7'b010_0000,
        PH_STOP  = 7'b100_0000
    } phase_t;

    // All results caused by one request, in order.
    typedef struct packed {
        logic [MAX_RESULTS-1:0][7:0] data;
        logic [MAX_RESULTS-1:0]      stop;
        logic [RES_CNT_W-1:0]        count;
    } bundle_t;

endpackage

[sv/bsed_front.sv]
// Front part: accepts requests, runs the escape parser and builds result bundles.
`timescale 1ns / 1ps

module bsed_front (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              cfg_we,
    input  logic              cfg_wdata,
    input  logic              in_valid,
    output logic              in_stall,
    input  logic [7:0]        in_byte,
    input  logic              end_of_string,
    input  logic              q_full,
    output logic              push,
    output bsed_pkg::bundle_t push_data
);

    bsed_pkg::phase_t phase_reg;
    logic [31:0]      acc_reg;
    logic [3:0]       cnt_reg;
    logic             b_mode_reg;

    bsed_pkg::phase_t phase_next;
    logic [31:0]      acc_next;
    logic [3:0]       cnt_next;
    bsed_pkg::bundle_t res;
    logic             accept;

    function automatic bsed_pkg::bundle_t add_result(bsed_pkg::bundle_t b, logic [7:0] d,
                                                     logic s);
        bsed_pkg::bundle_t r;
        r = b;
        if (r.count < bsed_pkg::RES_CNT_W'(bsed_pkg::MAX_RESULTS))
        begin
            r.data[r.count[bsed_pkg::RES_IDX_W-1:0]] = d;
            r.stop[r.count[bsed_pkg::RES_IDX_W-1:0]] = s;
            r.count = r.count + bsed_pkg::RES_CNT_W'(1);
        end
        return r;
    endfunction

    function automatic bsed_pkg::bundle_t add_utf8(bsed_pkg::bundle_t b, logic [31:0] cp);
        bsed_pkg::bundle_t r;
        r = b;
        if (cp <= bsed_pkg::CP_MAX_1BYTE)
        begin
            r = add_result(r, cp[7:0], 1'b0);
        end
        else if (cp <= bsed_pkg::CP_MAX_2BYTE)
        begin
            r = add_result(r, bsed_pkg::UTF8_LEAD2 | {3'b000, cp[10:6]}, 1'b0);
            r = add_result(r, bsed_pkg::UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
        end
        else if (cp <= bsed_pkg::CP_MAX_3BYTE)
        begin
            r = add_result(r, bsed_pkg::UTF8_LEAD3 | {4'b0000, cp[15:12]}, 1'b0);
            r = add_result(r, bsed_pkg::UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
            r = add_result(r, bsed_pkg::UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
        end
        else if (cp <= bsed_pkg::CP_MAX_4BYTE)
        begin
            r = add_result(r, bsed_pkg::UTF8_LEAD4 | {5'b00000, cp[20:18]}, 1'b0);
            r = add_result(r, bsed_pkg::UTF8_CONT | {2'b00, cp[17:12]}, 1'b0);
            r = add_result(r, bsed_pkg::UTF8_CONT | {2'b00, cp[11:6]}, 1'b0);
            r = add_result(r, bsed_pkg::UTF8_CONT | {2'b00, cp[5:0]}, 1'b0);
        end
        return r;
    endfunction

    function automatic bsed_pkg::bundle_t add_flush(bsed_pkg::bundle_t b, bsed_pkg::phase_t ph,
                                                    logic [31:0] acc, logic [3:0] cnt);
        bsed_pkg::bundle_t r;
        r = b;
        case (ph)
            bsed_pkg::PH_ESC:
            begin
                r = add_result(r, bsed_pkg::CH_BACKSLASH, 1'b0);
            end
            bsed_pkg::PH_HEX:
            begin
                r = add_result(r, (cnt == 4'd0) ? bsed_pkg::CH_LC_X : acc[7:0], 1'b0);
            end
            bsed_pkg::PH_UNI4:
            begin
                r = add_result(r, bsed_pkg::CH_BACKSLASH, 1'b0);
                r = add_result(r, bsed_pkg::CH_LC_U, 1'b0);
            end
            bsed_pkg::PH_UNI8:
            begin
                r = add_result(r, bsed_pkg::CH_BACKSLASH, 1'b0);
                r = add_result(r, bsed_pkg::CH_UC_U, 1'b0);
            end
            bsed_pkg::PH_OCT:
            begin
                r = add_result(r, acc[7:0], 1'b0);
            end
            default:
            begin
                r = b;
            end
        endcase
        return r;
    endfunction

    // Returns {is_hex, value}.
    function automatic logic [4:0] hex_nibble(logic [7:0] c);
        logic [4:0] v;
        v = 5'b0_0000;
        if (c inside {[bsed_pkg::CH_ZERO:bsed_pkg::CH_NINE]})
        begin
            v = {1'b1, c[3:0]};
        end
        else if (c inside {[bsed_pkg::CH_LC_A:bsed_pkg::CH_LC_F],
                           [bsed_pkg::CH_UC_A:bsed_pkg::CH_UC_F]})
        begin
            v = {1'b1, c[3:0] + 4'd9};
        end
        return v;
    endfunction

    always_comb
    begin
        logic       fresh;
        logic [4:0] hx;
        logic [3:0] want;
        phase_next = phase_reg;
        acc_next   = acc_reg;
        cnt_next   = cnt_reg;
        res        = '0;
        fresh      = 1'b0;
        hx         = hex_nibble(in_byte);
        want       = 4'd8;
        case (phase_reg)
            bsed_pkg::PH_STOP:
            begin
                fresh = 1'b0;
            end
            bsed_pkg::PH_ESC:
            begin
                phase_next = bsed_pkg::PH_PLAIN;
                acc_next   = '0;
                cnt_next   = '0;
                case (in_byte)
                    bsed_pkg::CH_LC_A: res = add_result(res, bsed_pkg::CODE_BEL, 1'b0);
                    bsed_pkg::CH_LC_B: res = add_result(res, bsed_pkg::CODE_BS, 1'b0);
                    bsed_pkg::CH_LC_C:
                    begin
                        res        = add_result(res, 8'h00, 1'b1);
                        phase_next = bsed_pkg::PH_STOP;
                    end
                    bsed_pkg::CH_LC_E,
                    bsed_pkg::CH_UC_E: res = add_result(res, bsed_pkg::CODE_ESC, 1'b0);
                    bsed_pkg::CH_LC_F: res = add_result(res, bsed_pkg::CODE_FF, 1'b0);
                    bsed_pkg::CH_LC_N: res = add_result(res, bsed_pkg::CODE_LF, 1'b0);
                    bsed_pkg::CH_LC_R: res = add_result(res, bsed_pkg::CODE_CR, 1'b0);
                    bsed_pkg::CH_LC_T: res = add_result(res, bsed_pkg::CODE_TAB, 1'b0);
                    bsed_pkg::CH_LC_V: res = add_result(res, bsed_pkg::CODE_VT, 1'b0);
                    bsed_pkg::CH_LC_X: phase_next = bsed_pkg::PH_HEX;
                    bsed_pkg::CH_LC_U: phase_next = bsed_pkg::PH_UNI4;
                    bsed_pkg::CH_UC_U: phase_next = bsed_pkg::PH_UNI8;
                    default:
                    begin
                        if ((in_byte inside {[bsed_pkg::CH_ZERO:bsed_pkg::CH_SEVEN]}) &&
                            (!b_mode_reg || (in_byte == bsed_pkg::CH_ZERO)))
                        begin
                            phase_next = bsed_pkg::PH_OCT;
                            if (!b_mode_reg)
                            begin
                                acc_next = {29'd0, in_byte[2:0]};
                                cnt_next = 4'd1;
                            end
                        end
                        else
                        begin
                            res = add_result(res, in_byte, 1'b0);
                        end
                    end
                endcase
            end
            bsed_pkg::PH_HEX,
            bsed_pkg::PH_UNI4,
            bsed_pkg::PH_UNI8:
            begin
                if (hx[4])
                begin
                    if (phase_reg == bsed_pkg::PH_HEX)
                    begin
                        want = 4'd2;
                    end
                    else if (phase_reg == bsed_pkg::PH_UNI4)
                    begin
                        want = 4'd4;
                    end
                    acc_next = {acc_reg[27:0], hx[3:0]};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= want)
                    begin
                        if (phase_reg == bsed_pkg::PH_HEX)
                        begin
                            res = add_result(res, acc_next[7:0], 1'b0);
                        end
                        else if ((acc_next >= bsed_pkg::CP_SURR_FIRST) &&
                                 (acc_next <= bsed_pkg::CP_SURR_LAST))
                        begin
                            res = add_result(res, bsed_pkg::CH_BACKSLASH, 1'b0);
                            res = add_result(res, (phase_reg == bsed_pkg::PH_UNI4) ?
                                             bsed_pkg::CH_LC_U : bsed_pkg::CH_UC_U, 1'b0);
                        end
                        else
                        begin
                            res = add_utf8(res, acc_next);
                        end
                        phase_next = bsed_pkg::PH_PLAIN;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
                else
                begin
                    res        = add_flush(res, phase_reg, acc_reg, cnt_reg);
                    phase_next = bsed_pkg::PH_PLAIN;
                    acc_next   = '0;
                    cnt_next   = '0;
                    fresh      = 1'b1;
                end
            end
            bsed_pkg::PH_OCT:
            begin
                if (in_byte inside {[bsed_pkg::CH_ZERO:bsed_pkg::CH_SEVEN]})
                begin
                    acc_next = {acc_reg[28:0], in_byte[2:0]};
                    cnt_next = cnt_reg + 4'd1;
                    if (cnt_next >= 4'd3)
                    begin
                        res        = add_result(res, acc_next[7:0], 1'b0);
                        phase_next = bsed_pkg::PH_PLAIN;
                        acc_next   = '0;
                        cnt_next   = '0;
                    end
                end
                else
                begin
                    res        = add_flush(res, phase_reg, acc_reg, cnt_reg);
                    phase_next = bsed_pkg::PH_PLAIN;
                    acc_next   = '0;
                    cnt_next   = '0;
                    fresh      = 1'b1;
                end
            end
            default:
            begin
                phase_next = bsed_pkg::PH_PLAIN;
                acc_next   = '0;
                cnt_next   = '0;
                fresh      = 1'b1;
            end
        endcase

        if (fresh)
        begin
            if (in_byte == bsed_pkg::CH_BACKSLASH)
            begin
                phase_next = bsed_pkg::PH_ESC;
            end
            else
            begin
                res = add_result(res, in_byte, 1'b0);
            end
        end

        // The end of a string flushes whatever is pending and clears the parser.
        if (end_of_string)
        begin
            res        = add_flush(res, phase_next, acc_next, cnt_next);
            phase_next = bsed_pkg::PH_PLAIN;
            acc_next   = '0;
            cnt_next   = '0;
        end
    end

    assign in_stall  = q_full;
    assign accept    = in_valid && !in_stall;
    assign push      = accept && (res.count != '0);
    assign push_data = res;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg  <= bsed_pkg::PH_PLAIN;
            acc_reg    <= '0;
            cnt_reg    <= '0;
            b_mode_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                b_mode_reg <= cfg_wdata;
            end
            if (accept)
            begin
                phase_reg <= phase_next;
                acc_reg   <= acc_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

endmodule

[sv/bsed_queue.sv]
// Short queue of result bundles between the parser and the output serializer.
`timescale 1ns / 1ps

module bsed_queue #(
    parameter int DEPTH = bsed_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  bsed_pkg::bundle_t push_data,
    input  logic              pop,
    output bsed_pkg::bundle_t head,
    output logic              head_valid,
    output logic              full
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    bsed_pkg::bundle_t entries_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg;
    logic [PTR_W-1:0]  rd_ptr_reg;
    logic [CNT_W-1:0]  count_reg;

    logic [PTR_W-1:0]  wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_next;
    logic [CNT_W-1:0]  count_next;

    assign head       = entries_reg[rd_ptr_reg];
    assign head_valid = (count_reg != '0);
    assign full       = (count_reg == CNT_W'(DEPTH));

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entries_reg[wr_ptr_reg] <= push_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

[sv/bsed_back.sv]
// Back part: hands out the results of the head bundle one per cycle while out_stall is low.
`timescale 1ns / 1ps

module bsed_back (
    input  logic              clk,
    input  logic              rst_n,
    input  bsed_pkg::bundle_t head,
    input  logic              head_valid,
    output logic              pop,
    output logic              out_valid,
    input  logic              out_stall,
    output logic [7:0]        out_byte,
    output logic              stop_marker,
    output logic              run_last
);

    logic [bsed_pkg::RES_IDX_W-1:0] idx_reg;
    logic [bsed_pkg::RES_IDX_W-1:0] idx_next;
    logic                           take;

    assign out_valid   = head_valid;
    assign out_byte    = head.data[idx_reg];
    assign stop_marker = head.stop[idx_reg];
    assign run_last    = (bsed_pkg::RES_CNT_W'(idx_reg) + bsed_pkg::RES_CNT_W'(1)) == head.count;
    assign take        = out_valid && !out_stall;
    assign pop         = take && run_last;

    always_comb
    begin
        idx_next = idx_reg;
        if (pop)
        begin
            idx_next = '0;
        end
        else if (take)
        begin
            idx_next = idx_reg + bsed_pkg::RES_IDX_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg <= '0;
        end
        else
        begin
            idx_reg <= idx_next;
        end
    end

endmodule

[sv/backslash_escape_decoder.sv]
// Top level: parser, bundle queue and output serializer of the backslash escape decoder.
// From an empty queue, a request's first result is offered in the cycle after acceptance.
// Throughput: one request per cycle while each gives at most one result and out_stall is low;
// a request with more results holds the output until its last is taken as the parser fills
// the QUEUE_DEPTH-bundle queue; once it is full every request stalls, even one with no result.
// Reset clears the parser to plain text, the %b mode bit to 0 and the queue to empty.
`timescale 1ns / 1ps

module backslash_escape_decoder #(
    parameter int QUEUE_DEPTH = bsed_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_we,
    input  logic       cfg_wdata,
    input  logic       in_valid,
    output logic       in_stall,
    input  logic [7:0] in_byte,
    input  logic       end_of_string,
    output logic       out_valid,
    input  logic       out_stall,
    output logic [7:0] out_byte,
    output logic       stop_marker,
    output logic       run_last
);

    bsed_pkg::bundle_t push_data;
    bsed_pkg::bundle_t head;
    logic              push;
    logic              pop;
    logic              head_valid;
    logic              q_full;

    bsed_front u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .q_full        (q_full),
        .push          (push),
        .push_data     (push_data)
    );

    bsed_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_data  (push_data),
        .pop        (pop),
        .head       (head),
        .head_valid (head_valid),
        .full       (q_full)
    );

    bsed_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head),
        .head_valid  (head_valid),
        .pop         (pop),
        .out_valid   (out_valid),
        .out_stall   (out_stall),
        .out_byte    (out_byte),
        .stop_marker (stop_marker),
        .run_last    (run_last)
    );

    // A full queue must also have a bundle to offer.
    a_full_has_head: assert property (@(posedge clk) disable iff (!rst_n)
        q_full |-> out_valid)
        else $error("queue full without a result at the output");

    // A request's results leave without a gap once the first one is taken.
    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_stall && !run_last) |=> out_valid)
        else $error("result run broken before its last result");

    // A stop marker carries no byte.
    a_stop_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && stop_marker) |-> (out_byte == 8'h00))
        else $error("stop marker with a nonzero byte");

    // A request is only accepted while the queue has room for its bundle.
    a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> !q_full)
        else $error("bundle pushed into a full queue");

endmodule

[test/tb.sv]
// Self-checking testbench for the backslash escape decoder, driven by directed and random strings.
`timescale 1ns / 1ps

module tb;
    import bsed_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int HOLD_CYCLES  = 100;

    typedef struct {
        logic [7:0] data;
        bit         stop;
        bit         last;
    } decoded_t;

    class escape_scoreboard;
        phase_t      phase = PH_PLAIN;
        logic [31:0] acc = '0;
        logic [3:0]  ndig = '0;
        bit          b_mode = 1'b0;
        decoded_t    step_q[$];
        decoded_t    decoded_q[$];
        int          errors = 0;
        int          checked = 0;
        int          stops = 0;

        function int nibble_of(logic [7:0] ch);
            if (ch >= CH_ZERO && ch <= CH_NINE) return int'(ch - CH_ZERO);
            if (ch >= CH_LC_A && ch <= CH_LC_F) return int'(ch - CH_LC_A) + 10;
            if (ch >= CH_UC_A && ch <= CH_UC_F) return int'(ch - CH_UC_A) + 10;
            return -1;
        endfunction

        function bit is_octal(logic [7:0] ch);
            return ch >= CH_ZERO && ch <= CH_SEVEN;
        endfunction

        function int pending();
            return decoded_q.size();
        endfunction

        function void clear_state();
            phase = PH_PLAIN;
            acc = '0;
            ndig = '0;
        endfunction

        function void put(logic [31:0] value, bit stop);
            decoded_t entry;
            if (step_q.size() >= MAX_RESULTS) return;
            entry.data = value[7:0];
            entry.stop = stop;
            entry.last = 1'b0;
            step_q.push_back(entry);
        endfunction

        function void put_utf8(logic [31:0] cp);
            if (cp <= CP_MAX_1BYTE)
            begin
                put(cp, 1'b0);
            end
            else if (cp <= CP_MAX_2BYTE)
            begin
                put(UTF8_LEAD2 | (cp >> 6), 1'b0);
                put(UTF8_CONT | cp[5:0], 1'b0);
            end
            else if (cp <= CP_MAX_3BYTE)
            begin
                put(UTF8_LEAD3 | (cp >> 12), 1'b0);
                put(UTF8_CONT | cp[11:6], 1'b0);
                put(UTF8_CONT | cp[5:0], 1'b0);
            end
            else if (cp <= CP_MAX_4BYTE)
            begin
                put(UTF8_LEAD4 | (cp >> 18), 1'b0);
                put(UTF8_CONT | cp[17:12], 1'b0);
                put(UTF8_CONT | cp[11:6], 1'b0);
                put(UTF8_CONT | cp[5:0], 1'b0);
            end
        endfunction

        function void finish_unicode(logic [7:0] letter);
            if (acc >= CP_SURR_FIRST && acc <= CP_SURR_LAST)
            begin
                put(CH_BACKSLASH, 1'b0);
                put(letter, 1'b0);
            end
            else
            begin
                put_utf8(acc);
            end
            clear_state();
        endfunction

        function void flush_pending();
            case (phase)
                PH_ESC:  put(CH_BACKSLASH, 1'b0);
                PH_HEX:  put((ndig == 0) ? CH_LC_X : acc[7:0], 1'b0);
                PH_UNI4:
                begin
                    put(CH_BACKSLASH, 1'b0);
                    put(CH_LC_U, 1'b0);
                end
                PH_UNI8:
                begin
                    put(CH_BACKSLASH, 1'b0);
                    put(CH_UC_U, 1'b0);
                end
                PH_OCT:  put(acc[7:0], 1'b0);
                default: ;
            endcase
            if (phase != PH_STOP) clear_state();
        endfunction

        function void after_backslash(logic [7:0] ch);
            clear_state();
            case (ch)
                CH_LC_A: put(CODE_BEL, 1'b0);
                CH_LC_B: put(CODE_BS, 1'b0);
                CH_LC_C:
                begin
                    put(0, 1'b1);
                    phase = PH_STOP;
                end
                CH_LC_E, CH_UC_E: put(CODE_ESC, 1'b0);
                CH_LC_F: put(CODE_FF, 1'b0);
                CH_LC_N: put(CODE_LF, 1'b0);
                CH_LC_R: put(CODE_CR, 1'b0);
                CH_LC_T: put(CODE_TAB, 1'b0);
                CH_LC_V: put(CODE_VT, 1'b0);
                CH_LC_X: phase = PH_HEX;
                CH_LC_U: phase = PH_UNI4;
                CH_UC_U: phase = PH_UNI8;
                default:
                begin
                    if (is_octal(ch) && (!b_mode || ch == CH_ZERO))
                    begin
                        phase = PH_OCT;
                        if (!b_mode)
                        begin
                            acc = 32'(ch - CH_ZERO);
                            ndig = 4'd1;
                        end
                    end
                    else
                    begin
                        put(ch, 1'b0);
                    end
                end
            endcase
        endfunction

        function void decode_char(logic [7:0] ch);
            int h;
            int want;
            case (phase)
                PH_STOP: return;
                PH_ESC:
                begin
                    after_backslash(ch);
                    return;
                end
                PH_HEX, PH_UNI4, PH_UNI8:
                begin
                    h = nibble_of(ch);
                    if (h >= 0)
                    begin
                        want = (phase == PH_HEX) ? 2 : ((phase == PH_UNI4) ? 4 : 8);
                        acc = (acc << 4) | 32'(h);
                        ndig = ndig + 4'd1;
                        if (ndig >= want)
                        begin
                            if (phase == PH_HEX)
                            begin
                                put(acc[7:0], 1'b0);
                                clear_state();
                            end
                            else
                            begin
                                finish_unicode((phase == PH_UNI4) ? CH_LC_U : CH_UC_U);
                            end
                        end
                        return;
                    end
                    flush_pending();
                end
                PH_OCT:
                begin
                    if (is_octal(ch))
                    begin
                        acc = (acc << 3) | 32'(ch - CH_ZERO);
                        ndig = ndig + 4'd1;
                        if (ndig >= 3)
                        begin
                            put(acc[7:0], 1'b0);
                            clear_state();
                        end
                        return;
                    end
                    flush_pending();
                end
                default: clear_state();
            endcase
            if (ch == CH_BACKSLASH) phase = PH_ESC;
            else put(ch, 1'b0);
        endfunction

        function void note_request(logic [7:0] ch, bit eos);
            step_q.delete();
            decode_char(ch);
            if (eos)
            begin
                flush_pending();
                clear_state();
            end
            foreach (step_q[i])
            begin
                step_q[i].last = (i == step_q.size() - 1);
                decoded_q.push_back(step_q[i]);
            end
        endfunction

        function void check_result(logic [7:0] data, logic stop, logic last);
            decoded_t want;
            if (decoded_q.size() == 0)
            begin
                $display("%0t: unexpected result: out_byte=%02h stop_marker=%0b run_last=%0b",
                         $time, data, stop, last);
                errors++;
                return;
            end
            want = decoded_q.pop_front();
            checked++;
            if (stop === 1'b1) stops++;
            if (data !== want.data)
            begin
                $display("%0t: out_byte mismatch: expected %02h, actual %02h",
                         $time, want.data, data);
                errors++;
            end
            if (stop !== want.stop)
            begin
                $display("%0t: stop_marker mismatch: expected %0b, actual %0b",
                         $time, want.stop, stop);
                errors++;
            end
            if (last !== want.last)
            begin
                $display("%0t: run_last mismatch: expected %0b, actual %0b",
                         $time, want.last, last);
                errors++;
            end
        endfunction
    endclass

    logic       clk;
    logic       rst_n;
    logic       cfg_we;
    logic       cfg_wdata;
    logic       in_valid;
    logic       in_stall;
    logic [7:0] in_byte;
    logic       end_of_string;
    logic       out_valid;
    logic       out_stall;
    logic [7:0] out_byte;
    logic       stop_marker;
    logic       run_last;

    escape_scoreboard sb;
    bit idle_on;
    bit hold_off_req;
    int items_sent;
    int cfg_writes;
    int cycle_count;

    backslash_escape_decoder u_top (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_wdata     (cfg_wdata),
        .in_valid      (in_valid),
        .in_stall      (in_stall),
        .in_byte       (in_byte),
        .end_of_string (end_of_string),
        .out_valid     (out_valid),
        .out_stall     (out_stall),
        .out_byte      (out_byte),
        .stop_marker   (stop_marker),
        .run_last      (run_last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("Regression FAIL");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        if (rst_n && out_valid && !out_stall) sb.check_result(out_byte, stop_marker, run_last);
    end

    initial
    begin
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_off_req)
            begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
                out_stall <= 1'b0;
                hold_off_req = 1'b0;
            end
            else if (idle_on && $urandom_range(0, 5) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 5)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    function automatic logic [7:0] hex_char(logic [3:0] nibble, bit upper);
        if (nibble < 10) return CH_ZERO + 8'(nibble);
        return (upper ? CH_UC_A : CH_LC_A) + 8'(nibble - 10);
    endfunction

    task automatic send_request(input logic [7:0] ch, input logic eos);
        if (idle_on && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        in_valid      <= 1'b1;
        in_byte       <= ch;
        end_of_string <= eos;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        sb.note_request(ch, eos);
        items_sent++;
    endtask

    task automatic send_text(input string s, input bit eos_last);
        for (int i = 0; i < s.len(); i++) send_request(s[i], eos_last && (i == s.len() - 1));
    endtask

    task automatic wait_drained();
        in_valid <= 1'b0;
        while (sb.pending() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_b_mode(input bit value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        sb.b_mode = value;
        cfg_writes++;
    endtask

    task automatic send_run();
        logic [7:0]  run[$];
        logic [31:0] cp;
        int          kind;
        int          want;
        int          count;
        bit          upper;
        bit          eos;
        kind  = $urandom_range(0, 19);
        upper = $urandom_range(0, 1);
        case (kind)
            0, 1, 2: run.push_back(8'($urandom_range(0, 255)));
            3, 4:
            begin
                run.push_back(CH_BACKSLASH);
                case ($urandom_range(0, 9))
                    0: run.push_back(CH_LC_A);
                    1: run.push_back(CH_LC_B);
                    2: run.push_back(CH_LC_E);
                    3: run.push_back(CH_UC_E);
                    4: run.push_back(CH_LC_F);
                    5: run.push_back(CH_LC_N);
                    6: run.push_back(CH_LC_R);
                    7: run.push_back(CH_LC_T);
                    8: run.push_back(CH_LC_V);
                    default: run.push_back(CH_BACKSLASH);
                endcase
            end
            5:
            begin
                run.push_back(CH_BACKSLASH);
                run.push_back(8'($urandom_range(0, 255)));
            end
            6:
            begin
                run.push_back(CH_BACKSLASH);
                run.push_back(CH_LC_C);
                repeat ($urandom_range(1, 3)) run.push_back(8'($urandom_range(0, 255)));
            end
            7, 8:
            begin
                run.push_back(CH_BACKSLASH);
                run.push_back(CH_LC_X);
                repeat ($urandom_range(0, 2)) run.push_back(hex_char(4'($urandom()), upper));
            end
            9, 10, 11, 12, 13, 14:
            begin
                run.push_back(CH_BACKSLASH);
                if (kind < 12)
                begin
                    run.push_back(CH_LC_U);
                    want = 4;
                    case ($urandom_range(0, 3))
                        0: cp = $urandom_range(0, 'h7F);
                        1: cp = $urandom_range('h80, 'h7FF);
                        2: cp = $urandom_range('h800, 'hFFFF);
                        default: cp = $urandom_range('hD800, 'hDFFF);
                    endcase
                end
                else
                begin
                    run.push_back(CH_UC_U);
                    want = 8;
                    case ($urandom_range(0, 5))
                        0: cp = $urandom_range(0, 'h7F);
                        1: cp = $urandom_range('h80, 'h7FF);
                        2: cp = $urandom_range('h800, 'hFFFF);
                        3: cp = $urandom_range('hD800, 'hDFFF);
                        4: cp = $urandom_range('h10000, 'h10FFFF);
                        default: cp = $urandom_range('h110000, 'hFFFFFFFF);
                    endcase
                end
                count = ($urandom_range(0, 4) == 0) ? $urandom_range(0, want - 1) : want;
                for (int i = 0; i < count; i++)
                    run.push_back(hex_char(4'(cp >> (4 * (want - 1 - i))), upper));
            end
            15, 16:
            begin
                run.push_back(CH_BACKSLASH);
                if (sb.b_mode && $urandom_range(0, 3) != 0) run.push_back(CH_ZERO);
                else run.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
                repeat ($urandom_range(0, 3)) run.push_back(CH_ZERO + 8'($urandom_range(0, 7)));
            end
            17:
            begin
                repeat ($urandom_range(1, 4))
                begin
                    case ($urandom_range(0, 3))
                        0: run.push_back(CH_BACKSLASH);
                        1: run.push_back(hex_char(4'($urandom()), upper));
                        2: run.push_back(CH_ZERO + 8'($urandom_range(0, 9)));
                        default: run.push_back(8'($urandom_range(0, 255)));
                    endcase
                end
            end
            default: repeat ($urandom_range(1, 3)) run.push_back(8'($urandom_range(32, 126)));
        endcase
        foreach (run[i])
        begin
            if (i == run.size() - 1) eos = ($urandom_range(0, 3) == 0);
            else eos = ($urandom_range(0, 49) == 0);
            send_request(run[i], eos);
        end
    endtask

    task automatic send_runs(input int n);
        int start;
        start = items_sent;
        while (items_sent - start < n) send_run();
    endtask

    initial
    begin
        sb = new;
        idle_on       = 1'b1;
        hold_off_req  = 1'b0;
        items_sent    = 0;
        cfg_writes    = 0;
        cycle_count   = 0;
        rst_n         <= 1'b0;
        cfg_we        <= 1'b0;
        cfg_wdata     <= 1'b0;
        in_valid      <= 1'b0;
        in_byte       <= 8'h00;
        end_of_string <= 1'b0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_request(8'h00, 1'b0);
        send_request(8'hFF, 1'b0);
        send_text("\\e", 1'b0);
        send_text("\\cz", 1'b1);
        send_text("\\xg", 1'b0);
        send_text("\\uD800", 1'b0);
        send_text("\\U0010FFFF", 1'b0);
        send_text("\\", 1'b1);
        wait_drained();

        write_b_mode(1'b1);
        send_text("\\0123\\7", 1'b1);
        send_runs(120);

        hold_off_req = 1'b1;
        send_runs(40);
        wait_drained();

        write_b_mode(1'b0);
        send_runs(150);
        wait_drained();

        write_b_mode(1'b1);
        send_runs(100);
        wait_drained();

        write_b_mode(1'b0);
        idle_on = 1'b0;
        send_runs(130);
        wait_drained();

        $display("Checked %0d decoded results (%0d stop markers) from %0d input bytes.",
                 sb.checked, sb.stops, items_sent);
        $display("Both octal modes ran over %0d register writes, with idle bursts and a long hold.",
                 cfg_writes);
        if (sb.errors == 0 && sb.pending() == 0)
        begin
            $display("Regression PASS");
        end
        else
        begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
